/* src/plra_pkg.sv */
// ----------------------------------------------------------------------------
// plra_pkg
// shared widths and register indexes of the path length and rotation block
// ----------------------------------------------------------------------------
`default_nettype none

package plra_pkg;

  localparam int DIST_W    = 48;  // path total
  localparam int ROT_W     = 40;  // heading total
  localparam int YAW_W     = 16;  // heading sample
  localparam int CFG_W     = 16;  // register data
  localparam int CFG_IDX_W = 2;   // register index

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_STEP   = 2'd0,
    CFG_WRAP_LIMIT = 2'd1
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] MIN_STEP_RST   = 16'd4;
  localparam logic [CFG_W-1:0] WRAP_LIMIT_RST = 16'd48898;

endpackage

`default_nettype wire

/* src/path_length_and_rotation_accumulator.sv */
// ----------------------------------------------------------------------------
// path_length_and_rotation_accumulator
// odometry totals: path length and absolute heading change from pose samples
// ----------------------------------------------------------------------------
// steps: in idle a pose word is taken, then the bit-serial square and the
//   restoring root run, each one bit a cycle, and the totals update once the
//   output slot is free; the first sample after reset skips the root
// flow: a new pose word is taken only in idle, after the last total is placed
// reset: rst_n synchronous, active low; totals and previous pose cleared,
//   min_step = 4, wrap_limit = 48898
// ----------------------------------------------------------------------------
`default_nettype none

module path_length_and_rotation_accumulator #(
  parameter int POSITION_BITS = 28,
  parameter int FULL_TURN     = 51472
) (
  input  wire logic clk,
  input  wire logic rst_n,

  // pose words
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // pos_x, pos_y, yaw_angle from the lowest bit up, zero padded to bytes
  input  wire logic [((2*POSITION_BITS+16+7)/8)*8-1:0] in_tdata,

  // total words
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // total_distance [47:0], total_rotation [87:48]
  output logic [87:0]                 out_tdata,

  // register writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [plra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [plra_pkg::CFG_W-1:0]     cfg_data
);

  localparam int P    = POSITION_BITS;
  localparam int R    = P + 1;
  localparam int YW   = plra_pkg::YAW_W;
  localparam int DW   = plra_pkg::DIST_W;
  localparam int RW   = plra_pkg::ROT_W;
  localparam int FT_W = $clog2(FULL_TURN + 1);
  localparam int TW   = (FT_W > YW) ? FT_W : YW;   // heading change width
  localparam logic [TW-1:0] FULL_C = TW'(FULL_TURN);

  typedef enum logic [1:0] {S_IDLE, S_BUSY, S_DONE} state_t;

  // control state
  state_t  state_r;
  logic    have_prev_r;
  logic    skip_r;
  logic    out_valid_r;

  // configuration
  logic [plra_pkg::CFG_W-1:0] min_step_r;
  logic [plra_pkg::CFG_W-1:0] wrap_limit_r;

  // previous pose and totals
  logic [P-1:0]  last_x_r, last_y_r;
  logic [YW-1:0] last_yaw_r;
  logic [TW-1:0] turn_r;
  logic [DW-1:0] dist_r;
  logic [RW-1:0] rot_r;

  // unpacked input fields
  logic [P-1:0]  pos_x, pos_y;
  logic [YW-1:0] yaw;

  // step length datapath
  logic [P:0]    ddx, ddy;
  logic [P-1:0]  mag_x, mag_y;
  logic          accept;
  logic          step_start;
  logic          step_done;
  logic [R-1:0]  step_len;

  // heading change and totals
  logic [YW-1:0] yaw_diff;
  logic [TW-1:0] turn_raw, turn_nxt;
  logic [DW:0]   dist_sum;
  logic [RW:0]   rot_sum;
  logic          step_ok;
  logic          out_free;

  assign pos_x = in_tdata[P-1:0];
  assign pos_y = in_tdata[2*P-1:P];
  assign yaw   = in_tdata[2*P+YW-1:2*P];

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign step_start = accept && have_prev_r;
  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;

  // sign-extended differences, then magnitude (always fits P bits)
  always_comb begin
    ddx   = {pos_x[P-1], pos_x} - {last_x_r[P-1], last_x_r};
    ddy   = {pos_y[P-1], pos_y} - {last_y_r[P-1], last_y_r};
    mag_x = ddx[P] ? P'(~ddx + 1'b1) : ddx[P-1:0];
    mag_y = ddy[P] ? P'(~ddy + 1'b1) : ddy[P-1:0];
  end

  // heading change; near a full turn it is taken as wrap-around
  always_comb begin
    yaw_diff = (yaw >= last_yaw_r) ? (yaw - last_yaw_r) : (last_yaw_r - yaw);
    turn_raw = TW'(yaw_diff);
    if (yaw_diff >= wrap_limit_r) begin
      turn_nxt = (turn_raw >= FULL_C) ? (turn_raw - FULL_C) : (FULL_C - turn_raw);
    end else begin
      turn_nxt = turn_raw;
    end
  end

  // saturating totals, carry out means clamp to all ones
  always_comb begin
    step_ok  = (step_len > R'(min_step_r));
    dist_sum = {1'b0, dist_r} + (step_ok ? (DW + 1)'(step_len) : '0);
    rot_sum  = {1'b0, rot_r} + (RW + 1)'(turn_r);
  end

  plra_step #(
    .POSITION_BITS(P)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .start (step_start),
    .dx    (mag_x),
    .dy    (mag_y),
    .done  (step_done),
    .root  (step_len)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      have_prev_r  <= 1'b0;
      skip_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      min_step_r   <= plra_pkg::MIN_STEP_RST;
      wrap_limit_r <= plra_pkg::WRAP_LIMIT_RST;
      last_x_r     <= '0;
      last_y_r     <= '0;
      last_yaw_r   <= '0;
      dist_r       <= '0;
      rot_r        <= '0;
    end else begin
      // register writes, indexes past the list are dropped
      if (cfg_valid) begin
        case (cfg_index)
          plra_pkg::CFG_MIN_STEP:   min_step_r   <= cfg_data;
          plra_pkg::CFG_WRAP_LIMIT: wrap_limit_r <= cfg_data;
          default: ;
        endcase
      end

      // word taken; in S_DONE the valid flag is set below instead
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            last_x_r    <= pos_x;
            last_y_r    <= pos_y;
            last_yaw_r  <= yaw;
            turn_r      <= turn_nxt;
            have_prev_r <= 1'b1;
            skip_r      <= !have_prev_r;
            // first sample skips the root and adds nothing
            state_r     <= have_prev_r ? S_BUSY : S_DONE;
          end
        end
        S_BUSY: begin
          if (step_done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // totals double as the output word, so wait for a free slot
          if (out_free) begin
            if (!skip_r) begin
              dist_r <= dist_sum[DW] ? '1 : dist_sum[DW-1:0];
              rot_r  <= rot_sum[RW]  ? '1 : rot_sum[RW-1:0];
            end
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {rot_r, dist_r};

endmodule

`default_nettype wire

/* src/plra_step.sv */
// ----------------------------------------------------------------------------
// plra_step
// bit-serial step length: floor(sqrt(dx*dx + dy*dy)), squares by shift-add
// one multiplier bit a cycle, then a restoring root one result bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module plra_step #(
  parameter int POSITION_BITS = 28
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [POSITION_BITS-1:0] dx,
  input  wire logic [POSITION_BITS-1:0] dy,
  output logic                          done,
  output logic [POSITION_BITS:0]        root
);

  localparam int P  = POSITION_BITS;
  localparam int R  = P + 1;        // root bits
  localparam int NW = 2 * R;        // radicand bits, even
  localparam int CW = $clog2(R);

  typedef enum logic [1:0] {ST_IDLE, ST_SQ, ST_RT} state_t;

  state_t        state_r;
  logic [CW-1:0] cnt_r;
  logic [P-1:0]  dx_r, dy_r, mx_r, my_r;
  logic [NW-1:0] acc_r;
  logic [R+1:0]  rem_r;
  logic [R-1:0]  root_r;
  logic          done_r;

  logic [NW-1:0] sq_nxt;
  logic [R+1:0]  shifted;
  logic [R+1:0]  trial;
  logic          take;

  always_comb begin
    sq_nxt = {acc_r[NW-2:0], 1'b0}
           + (mx_r[P-1] ? NW'(dx_r) : '0)
           + (my_r[P-1] ? NW'(dy_r) : '0);
    shifted = {rem_r[R-1:0], acc_r[NW-1:NW-2]};
    trial   = {root_r, 2'b01};
    take    = (shifted >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      // pulse after the last root bit
      done_r <= (state_r == ST_RT) && (cnt_r == CW'(R - 1));
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            dx_r    <= dx;
            dy_r    <= dy;
            mx_r    <= dx;
            my_r    <= dy;
            acc_r   <= '0;
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= '0;
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          acc_r <= sq_nxt;
          mx_r  <= {mx_r[P-2:0], 1'b0};
          my_r  <= {my_r[P-2:0], 1'b0};
          if (cnt_r == CW'(P - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_RT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_RT: begin
          acc_r  <= {acc_r[NW-3:0], 2'b00};
          rem_r  <= take ? (shifted - trial) : shifted;
          root_r <= {root_r[R-2:0], take};
          if (cnt_r == CW'(R - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

/* tb/path_length_and_rotation_accumulator_tb.sv */
// ----------------------------------------------------------------------------
// path_length_and_rotation_accumulator_tb
// drives pose words through the odometry accumulator and checks every total
// word against a cycle-free model of the path and heading sums; register
// settings change between phases while the block is idle, and both stream
// sides idle and stall at random
// ----------------------------------------------------------------------------
`default_nettype none

module path_length_and_rotation_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int YAW_W     = plra_pkg::YAW_W;
  localparam int DIST_W    = plra_pkg::DIST_W;
  localparam int ROT_W     = plra_pkg::ROT_W;
  localparam int CFG_W     = plra_pkg::CFG_W;
  localparam int CFG_IDX_W = plra_pkg::CFG_IDX_W;

  localparam int POS_W       = 28;
  localparam int FULL_TURN   = 51472;
  localparam int IN_W        = ((2*POS_W+YAW_W+7)/8)*8;
  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 8;
  // one result per pose word; square plus root run one bit a cycle
  localparam int LATENCY     = 2*POS_W + 3;
  localparam int TAIL_CYCLES = LATENCY + 40;
  // about 750 words at latency plus both sides' worst gaps, several times over
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 140;

  // index that decodes to no register, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = {CFG_IDX_W{1'b1}};

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam longint unsigned DIST_TOP = {DIST_W{1'b1}};
  localparam longint unsigned ROT_TOP  = {ROT_W{1'b1}};

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [YAW_W-1:0]        yaw;
  } pose_t;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic [ROT_W-1:0]  rot;
  } totals_t;

  // dut ports, the driven ones known from time zero
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;   // pos_x, pos_y, yaw_angle
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DIST_W+ROT_W-1:0] out_tdata;       // total_distance, total_rotation
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_data   = '0;

  // pose words waiting to be sent, totals waiting to come back
  pose_t   pose_backlog[$];
  totals_t expected_totals[$];
  int      poses_queued = 0;
  int      poses_taken  = 0;
  int      mismatches   = 0;
  int      cycle_count  = 0;

  // model state: previous pose, running totals, register copies
  pose_t                prev_pose;
  bit                   pose_seen    = 1'b0;
  longint unsigned      path_total   = 0;
  longint unsigned      turn_total   = 0;
  logic [CFG_W-1:0]     jitter_floor = plra_pkg::MIN_STEP_RST;
  logic [CFG_W-1:0]     wrap_thresh  = plra_pkg::WRAP_LIMIT_RST;

  // stimulus generator walks from the last queued pose
  pose_t gen_pose = '{x: '0, y: '0, yaw: '0};

  // sender and receiver pacing
  pose_t pose_in_flight;
  int    sender_gap    = 0;
  bit    sender_calm   = 1'b0;
  bit    send_next;
  int    receiver_hold = 0;
  bit    receiver_calm = 1'b0;
  totals_t seen_totals;

  path_length_and_rotation_accumulator #(
    .POSITION_BITS (POS_W),
    .FULL_TURN     (FULL_TURN)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic longint unsigned sat_sum(longint unsigned acc, longint unsigned inc,
                                              longint unsigned top);
    return (inc >= top - acc) ? top : acc + inc;
  endfunction

  // advance the totals by one pose word and return what the block should report
  function automatic totals_t odometry_update(pose_t p);
    longint          dx, dy;
    longint unsigned sq, root, cand;
    int unsigned     turn;
    int              b;
    totals_t         t;
    if (pose_seen) begin
      dx = longint'(p.x) - longint'(prev_pose.x);
      dy = longint'(p.y) - longint'(prev_pose.y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sq = dx*dx + dy*dy;
      // exact integer root, one bit at a time
      root = 0;
      for (b = 29; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand*cand <= sq) root = cand;
      end
      // steps not above the floor are jitter
      if (root > jitter_floor) path_total = sat_sum(path_total, root, DIST_TOP);
      turn = (p.yaw >= prev_pose.yaw) ? p.yaw - prev_pose.yaw : prev_pose.yaw - p.yaw;
      // a jump across zero heading counts the short way round
      if (turn >= wrap_thresh)
        turn = (turn >= FULL_TURN) ? turn - FULL_TURN : FULL_TURN - turn;
      turn_total = sat_sum(turn_total, turn, ROT_TOP);
    end
    prev_pose = p;
    pose_seen = 1'b1;
    t.distance = path_total[DIST_W-1:0];
    t.rot      = turn_total[ROT_W-1:0];
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // pose driver: one word from the backlog at a time, random gap after each
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      send_next = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_totals.push_back(odometry_update(pose_in_flight));
        poses_taken++;
        send_next = 1'b0;
        // now and then switch between gapless stretches and random gaps
        if ($urandom_range(0, 29) == 0) sender_calm = !sender_calm;
        sender_gap = sender_calm ? 0 : $urandom_range(0, 11);
      end
      if (!send_next) begin
        if (sender_gap > 0) begin
          sender_gap--;
        end else if (pose_backlog.size() > 0) begin
          pose_in_flight = pose_backlog.pop_front();
          in_tdata  <= IN_W'({pose_in_flight.yaw, pose_in_flight.y, pose_in_flight.x});
          send_next = 1'b1;
        end
      end
      in_tvalid <= send_next;
    end
  end

  // ---------------------------------------------------------------------------
  // totals monitor: compare each accepted word, then stall a random while
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_totals.distance = out_tdata[DIST_W-1:0];
        seen_totals.rot      = out_tdata[DIST_W+ROT_W-1:DIST_W];
        if (expected_totals.size() == 0) begin
          $error("total word with none pending: total_distance %0d total_rotation %0d",
                 seen_totals.distance, seen_totals.rot);
          mismatches++;
        end else begin
          if (seen_totals.distance !== expected_totals[0].distance) begin
            $error("total_distance expected %0d, got %0d",
                   expected_totals[0].distance, seen_totals.distance);
            mismatches++;
          end
          if (seen_totals.rot !== expected_totals[0].rot) begin
            $error("total_rotation expected %0d, got %0d",
                   expected_totals[0].rot, seen_totals.rot);
            mismatches++;
          end
          void'(expected_totals.pop_front());
        end
        if ($urandom_range(0, 29) == 0) receiver_calm = !receiver_calm;
        receiver_hold = receiver_calm ? 0 : $urandom_range(0, 11);
      end else if (receiver_hold > 0) begin
        receiver_hold--;
      end
      out_tready <= (receiver_hold == 0);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic queue_pose(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                            input logic [YAW_W-1:0] yaw);
    pose_t p;
    p.x = x;
    p.y = y;
    p.yaw = yaw;
    pose_backlog.push_back(p);
    gen_pose = p;
    poses_queued++;
  endtask

  // register write over the config channel; model copy follows on acceptance
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      plra_pkg::CFG_MIN_STEP:   jitter_floor = val;
      plra_pkg::CFG_WRAP_LIMIT: wrap_thresh  = val;
      default: ;
    endcase
  endtask

  // every queued pose taken and every total word back
  task automatic wait_drained();
    do @(posedge clk); while (poses_taken != poses_queued || expected_totals.size() != 0);
  endtask

  // random walk around the current thresholds, with jumps and wild words mixed in
  task automatic queue_random_poses(input int count);
    pose_t p;
    int    mode, span, d, w, v;
    repeat (count) begin
      p = gen_pose;
      mode = $urandom_range(0, 99);
      if (mode < 55) begin
        // ordinary motion, step sizes straddling the jitter floor
        span = int'(jitter_floor) + 8;
        d = int'($urandom_range(0, 2*span)) - span;
        p.x = POS_W'(gen_pose.x + d);
        d = int'($urandom_range(0, 2*span)) - span;
        p.y = POS_W'(gen_pose.y + d);
        d = int'($urandom_range(0, 600)) - 300;
        v = int'(gen_pose.yaw) + d;
        if (v < 0) v += FULL_TURN;
        else if (v >= FULL_TURN) v -= FULL_TURN;
        p.yaw = YAW_W'(v);
      end else if (mode < 75) begin
        // step right at the floor along one axis, heading change right at the wrap limit
        d = int'(jitter_floor) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) p.x = POS_W'(gen_pose.x + d);
        else p.y = POS_W'(gen_pose.y - d);
        w = int'(wrap_thresh) + int'($urandom_range(0, 2)) - 1;
        if (w < 0) w = 0;
        v = (int'(gen_pose.yaw) >= w) ? int'(gen_pose.yaw) - w : int'(gen_pose.yaw) + w;
        if (v > 65535) v = 65535;
        p.yaw = YAW_W'(v);
      end else if (mode < 93) begin
        // teleport anywhere, heading in range
        p.x = POS_W'($urandom);
        p.y = POS_W'($urandom);
        p.yaw = YAW_W'($urandom_range(0, FULL_TURN-1));
      end else begin
        // edge of the position range, heading anywhere in 16 bits
        p.x = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
        p.y = POS_W'($urandom);
        p.yaw = YAW_W'($urandom);
      end
      queue_pose(p.x, p.y, p.yaw);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus: directed corners under three settings, then random phases
  // ---------------------------------------------------------------------------
  initial begin
    int ph;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: first sample, floor edge, wrap edge, range extremes
    queue_pose(0, 0, 0);
    queue_pose(4, 0, 0);                         // step equal to floor, dropped
    queue_pose(9, 0, 10);                        // step just over floor
    queue_pose(12, 4, 48908);                    // diagonal 3-4-5, change at wrap limit
    queue_pose(12, 4, 11);                       // change one below wrap limit
    queue_pose(POS_MAX, POS_MAX, YAW_W'(FULL_TURN-1));
    queue_pose(POS_MIN, POS_MIN, 0);             // longest possible step
    queue_pose(POS_MAX, POS_MIN, 16'hFFFF);      // heading past a full turn
    queue_pose(POS_MIN, POS_MAX, 0);
    queue_pose(POS_MIN, POS_MAX, YAW_W'(FULL_TURN)); // change of exactly one turn
    queue_pose(-1, -1, 1);
    queue_pose(0, 0, YAW_W'(FULL_TURN-1));
    wait_drained();

    // zero floor and zero wrap limit: no motion still adds a full turn
    write_reg(plra_pkg::CFG_MIN_STEP, '0);
    write_reg(plra_pkg::CFG_WRAP_LIMIT, '0);
    queue_pose(0, 0, YAW_W'(FULL_TURN-1));
    queue_pose(1, 0, YAW_W'(FULL_TURN-1));
    queue_pose(1, -1, 0);
    wait_drained();

    // all-ones settings, then a write to the unused index that must change nothing
    write_reg(plra_pkg::CFG_MIN_STEP, '1);
    write_reg(plra_pkg::CFG_WRAP_LIMIT, '1);
    write_reg(CFG_IDX_SPARE, '0);
    queue_pose(65536, -1, 16'hFFFF);             // step equal to floor, change wraps
    queue_pose(131072, -1, 0);                   // step one over floor
    queue_pose(131072, -1, 16'hFFFE);            // change one below wrap limit
    queue_pose(131072, 65535, 16'hFFFE);
    wait_drained();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(plra_pkg::CFG_MIN_STEP, plra_pkg::MIN_STEP_RST);
          write_reg(plra_pkg::CFG_WRAP_LIMIT, plra_pkg::WRAP_LIMIT_RST);
        end
        1: begin
          write_reg(plra_pkg::CFG_MIN_STEP, '0);
          write_reg(plra_pkg::CFG_WRAP_LIMIT, CFG_W'(FULL_TURN-1));
        end
        2: begin
          write_reg(plra_pkg::CFG_MIN_STEP, '1);
          write_reg(plra_pkg::CFG_WRAP_LIMIT, '0);
        end
        3: begin
          write_reg(plra_pkg::CFG_MIN_STEP, CFG_W'($urandom_range(0, 300)));
          write_reg(plra_pkg::CFG_WRAP_LIMIT, CFG_W'($urandom_range(0, FULL_TURN-1)));
        end
        default: begin
          write_reg(plra_pkg::CFG_MIN_STEP, CFG_W'($urandom));
          write_reg(plra_pkg::CFG_WRAP_LIMIT, CFG_W'($urandom));
        end
      endcase
      queue_random_poses(RANDOM_PER_PHASE);
      wait_drained();
    end

    // let any stray word show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
